// ===== design/qoi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// QOI frame decoder package
// Shared types, codes and a helper function of the frame decoder.
// ----------------------------------------------------------------------------
package qoi_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int SEEN_DEPTH = 64;

    localparam logic [4:0] POS_BODY = 5'd26;
    localparam logic [4:0] POS_DONE = 5'd27;
    localparam logic [4:0] POS_BAD  = 5'd31;

    localparam logic [7:0] OP_RGB = 8'hFE;

    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_SUB    = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_SHORT = 2'd1;
    localparam logic [1:0] ERR_HDR   = 2'd2;

    localparam logic [1:0] CLS_PLAIN = 2'd0;
    localparam logic [1:0] CLS_SETUP = 2'd1;
    localparam logic [1:0] CLS_INDEX = 2'd2;
    localparam logic [1:0] CLS_RUN   = 2'd3;

    typedef struct packed {
        logic accept;
        logic setup;
        logic idx_emit;
        logic run_emit;
    } cmd_t;

    typedef struct packed {
        logic [1:0] cls;
        logic       run_last;
        logic       out_free;
    } stat_t;

    function automatic logic [5:0] colour_hash(input logic [23:0] c);
        logic [5:0] r;
        logic [5:0] g;
        logic [5:0] b;
        r = c[21:16];
        g = c[13:8];
        b = c[5:0];
        return 6'(r * 6'd3 + g * 6'd5 + b * 6'd7 + 6'd53);
    endfunction

endpackage
`default_nettype wire

// ===== design/qoi_rgb_frame_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// QOI RGB frame decoder
// Byte-serial header parser and QOI-style RGB op decoder with flipped rows.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_ready   data_byte, frame_last
// out      output     out_valid / out_ready pixel_address, blue, green, red,
//                                           kind, frame_end, error_code,
//                                           last_of_item
//
// An index op emits its pixel from the S_IDX state, after the registered table read.
// A run op gives one pixel beat per cycle while the output register is free, up to 64 pixels.
// The byte that completes the header is followed by the S_SETUP state for the
// row address multiply. Reset clears all frame state and the color table valid bits.
// A stalled output register holds the input off until it drains.
// ----------------------------------------------------------------------------
module qoi_rgb_frame_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        frame_last,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [23:0]      pixel_address,
    output logic [7:0]       blue,
    output logic [7:0]       green,
    output logic [7:0]       red,
    output logic [1:0]       kind,
    output logic             frame_end,
    output logic [1:0]       error_code,
    output logic             last_of_item
);
    import qoi_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    qoi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    qoi_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .data_byte     (data_byte),
        .frame_last    (frame_last),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .pixel_address (pixel_address),
        .blue          (blue),
        .green         (green),
        .red           (red),
        .kind          (kind),
        .frame_end     (frame_end),
        .error_code    (error_code),
        .last_of_item  (last_of_item)
    );

endmodule
`default_nettype wire

// ===== design/qoi_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module qoi_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== design/qoi_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// QOI frame decoder datapath
// Header parsing, op decoding, cursor and address tracking, output register.
// ----------------------------------------------------------------------------
module qoi_dp (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire qoi_pkg::cmd_t cmd,
    output qoi_pkg::stat_t     stat,
    input  wire logic [7:0]    data_byte,
    input  wire logic          frame_last,
    input  wire logic          out_ready,
    output logic               out_valid,
    output logic [23:0]        pixel_address,
    output logic [7:0]         blue,
    output logic [7:0]         green,
    output logic [7:0]         red,
    output logic [1:0]         kind,
    output logic               frame_end,
    output logic [1:0]         error_code,
    output logic               last_of_item
);
    import qoi_pkg::*;

    logic [4:0]  pos_reg, pos_next;
    logic [1:0]  mode_reg, mode_next;
    logic [12:0] fw_reg, fw_next, fh_reg, fh_next;
    logic [11:0] rb_reg [4];
    logic [11:0] rb_next [4];
    logic [11:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [23:0] prev_reg, prev_next;
    logic [6:0]  run_reg, run_next;
    logic [63:0] vld_reg, vld_next;
    logic [7:0]  op_reg, op_next;
    logic [1:0]  pb_reg, pb_next;
    logic [15:0] part_reg, part_next;
    logic [31:0] acc_reg, acc_next;
    logic [23:0] row_reg, row_next;
    logic        hold_reg, hold_next;
    logic        ivld_reg, ivld_next;
    logic        ov_reg, ov_next;
    logic [23:0] oa_reg, oa_next;
    logic [23:0] oc_reg, oc_next;
    logic [1:0]  ok_reg, ok_next;
    logic        oe_reg, oe_next;
    logic [1:0]  oerr_reg, oerr_next;
    logic        ol_reg, ol_next;

    logic        emit, settle, end_frame, begin_body, at_end, fin, item_last;
    logic        run_last;
    logic [23:0] colour;
    logic [31:0] acc_sh;
    logic [11:0] nb [4];
    logic [7:0]  r8, g8, b8, vg;
    logic [1:0]  cls;
    logic [1:0]  k;
    logic [12:0] lim, hm;
    logic [25:0] prod;
    logic        we, re;
    logic [5:0]  waddr;
    logic [23:0] wdata, rdata;

    qoi_ram #(.WIDTH(24), .DEPTH(SEEN_DEPTH)) u_seen (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (data_byte[5:0]),
        .rdata (rdata)
    );

    assign at_end   = cx_reg >= rb_reg[2];
    assign fin      = at_end && (cy_reg >= rb_reg[3]);
    assign run_last = (run_reg == 7'd1) || fin;
    assign hm       = fh_reg - 13'd1 - {1'b0, cy_reg};
    assign prod     = hm * fw_reg;

    always_comb
    begin
        pos_next  = pos_reg;
        mode_next = mode_reg;
        fw_next   = fw_reg;
        fh_next   = fh_reg;
        for (int i = 0; i < 4; i++)
        begin
            rb_next[i] = rb_reg[i];
            nb[i]      = rb_reg[i];
        end
        cx_next   = cx_reg;
        cy_next   = cy_reg;
        prev_next = prev_reg;
        run_next  = run_reg;
        vld_next  = vld_reg;
        op_next   = op_reg;
        pb_next   = pb_reg;
        part_next = part_reg;
        acc_next  = acc_reg;
        row_next  = row_reg;
        hold_next = hold_reg;
        ivld_next = ivld_reg;
        emit      = 1'b0;
        settle    = 1'b0;
        end_frame = 1'b0;
        item_last = 1'b1;
        begin_body = 1'b0;
        colour    = 24'd0;
        cls       = CLS_PLAIN;
        we        = 1'b0;
        re        = 1'b0;
        waddr     = 6'd0;
        wdata     = 24'd0;
        acc_sh    = {acc_reg[23:0], data_byte};
        k         = 2'(pos_reg[4:2] - 3'd3);
        lim       = k[0] ? fh_reg : fw_reg;
        r8        = prev_reg[23:16];
        g8        = prev_reg[15:8];
        b8        = prev_reg[7:0];
        vg        = {2'b00, op_reg[5:0]} - 8'd32;

        if (pos_reg < POS_BODY)
        begin
            if (pos_reg == 5'd0)
            begin
                if (cmd.accept)
                begin
                    mode_next = data_byte[1:0];
                    acc_next  = 32'd0;
                    pos_next  = 5'd1;
                end
            end
            else
            begin
                if (cmd.accept)
                begin
                    acc_next = acc_sh;
                    pos_next = pos_reg + 5'd1;
                end
                if (pos_reg == 5'd4)
                begin
                    if (cmd.accept)
                    begin
                        fw_next = (acc_sh > 32'd8191) ? 13'd8191 : acc_sh[12:0];
                        if (acc_sh == 32'd0 || acc_sh > 32'(MAX_WIDTH))
                        begin
                            pos_next = POS_BAD;
                        end
                    end
                end
                else if (pos_reg == 5'd8)
                begin
                    if (cmd.accept)
                    begin
                        fh_next = (acc_sh > 32'd8191) ? 13'd8191 : acc_sh[12:0];
                    end
                    if (acc_sh == 32'd0 || acc_sh > 32'(MAX_HEIGHT))
                    begin
                        if (cmd.accept)
                        begin
                            pos_next = POS_BAD;
                        end
                    end
                    else if (mode_reg != 2'd1)
                    begin
                        begin_body = 1'b1;
                        nb[0] = 12'd0;
                        nb[1] = 12'd0;
                        nb[2] = 12'(fw_reg - 13'd1);
                        nb[3] = 12'(acc_sh[12:0] - 13'd1);
                    end
                end
                else if (pos_reg >= 5'd12 && pos_reg <= 5'd24 && pos_reg[1:0] == 2'd0)
                begin
                    if (acc_sh >= {19'd0, lim})
                    begin
                        if (cmd.accept)
                        begin
                            pos_next = POS_BAD;
                        end
                    end
                    else
                    begin
                        nb[k] = acc_sh[11:0];
                        if (cmd.accept)
                        begin
                            rb_next[k] = acc_sh[11:0];
                        end
                        if (pos_reg == 5'd24)
                        begin
                            begin_body = 1'b1;
                        end
                    end
                end
                if (cmd.accept && pos_reg[1:0] == 2'd0)
                begin
                    acc_next = 32'd0;
                end
            end
            if (begin_body)
            begin
                cls = CLS_SETUP;
                if (cmd.accept)
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        rb_next[i] = nb[i];
                    end
                    cx_next   = nb[0];
                    cy_next   = nb[1];
                    vld_next  = '0;
                    prev_next = 24'd0;
                    run_next  = 7'd0;
                    op_next   = 8'd0;
                    pb_next   = 2'd0;
                    part_next = 16'd0;
                    pos_next  = (nb[0] > nb[2] || nb[1] > nb[3]) ? POS_DONE : POS_BODY;
                end
            end
            end_frame = cmd.accept && frame_last;
        end
        else if (pos_reg == POS_BODY && cmd.accept)
        begin
            end_frame = frame_last;
            if (mode_reg == 2'd3)
            begin
                case (pb_reg)
                    2'd0:
                    begin
                        part_next = {data_byte, 8'd0};
                        pb_next   = 2'd1;
                    end
                    2'd1:
                    begin
                        part_next = {part_reg[15:8], data_byte};
                        pb_next   = 2'd2;
                    end
                    default:
                    begin
                        pb_next = 2'd0;
                        emit    = 1'b1;
                        colour  = {part_reg, data_byte};
                    end
                endcase
            end
            else if (pb_reg != 2'd0)
            begin
                if (op_reg == OP_RGB)
                begin
                    case (pb_reg)
                        2'd3:
                        begin
                            part_next = {data_byte, 8'd0};
                            pb_next   = 2'd2;
                        end
                        2'd2:
                        begin
                            part_next = {part_reg[15:8], data_byte};
                            pb_next   = 2'd1;
                        end
                        default:
                        begin
                            pb_next = 2'd0;
                            settle  = 1'b1;
                            colour  = {part_reg, data_byte};
                        end
                    endcase
                end
                else
                begin
                    pb_next = 2'd0;
                    settle  = 1'b1;
                    colour  = {r8 + vg - 8'd8 + {4'd0, data_byte[7:4]},
                               g8 + vg,
                               b8 + vg - 8'd8 + {4'd0, data_byte[3:0]}};
                end
            end
            else if (data_byte == OP_RGB)
            begin
                op_next = data_byte;
                pb_next = 2'd3;
            end
            else
            begin
                case (data_byte[7:6])
                    2'b00:
                    begin
                        re        = 1'b1;
                        ivld_next = vld_reg[data_byte[5:0]];
                        hold_next = frame_last;
                        end_frame = 1'b0;
                    end
                    2'b01:
                    begin
                        settle = 1'b1;
                        colour = {r8 + {6'd0, data_byte[5:4]} - 8'd2,
                                  g8 + {6'd0, data_byte[3:2]} - 8'd2,
                                  b8 + {6'd0, data_byte[1:0]} - 8'd2};
                    end
                    2'b10:
                    begin
                        op_next = data_byte;
                        pb_next = 2'd1;
                    end
                    default:
                    begin
                        we        = 1'b1;
                        waddr     = colour_hash(prev_reg);
                        wdata     = prev_reg;
                        vld_next[waddr] = 1'b1;
                        run_next  = {1'b0, data_byte[5:0]} + 7'd1;
                        hold_next = frame_last;
                        end_frame = 1'b0;
                    end
                endcase
            end
        end
        else if (cmd.accept)
        begin
            end_frame = frame_last;
        end

        if (pos_reg == POS_BODY && mode_reg != 2'd3 && pb_reg == 2'd0
            && data_byte != OP_RGB)
        begin
            if (data_byte[7:6] == 2'b00)
            begin
                cls = CLS_INDEX;
            end
            else if (data_byte[7:6] == 2'b11)
            begin
                cls = CLS_RUN;
            end
        end

        if (cmd.setup)
        begin
            row_next = prod[23:0];
        end

        if (cmd.idx_emit)
        begin
            settle    = 1'b1;
            colour    = ivld_reg ? rdata : 24'd0;
            end_frame = hold_reg;
        end

        if (cmd.run_emit)
        begin
            emit      = 1'b1;
            colour    = prev_reg;
            run_next  = run_reg - 7'd1;
            item_last = run_last;
            end_frame = hold_reg && run_last;
        end

        if (settle)
        begin
            emit      = 1'b1;
            prev_next = colour;
            we        = 1'b1;
            waddr     = colour_hash(colour);
            wdata     = colour;
            vld_next[waddr] = 1'b1;
        end

        if (emit)
        begin
            if (at_end)
            begin
                cx_next = rb_reg[0];
                if (fin)
                begin
                    pos_next = POS_DONE;
                end
                else
                begin
                    cy_next  = cy_reg + 12'd1;
                    row_next = row_reg - {11'd0, fw_reg};
                end
            end
            else
            begin
                cx_next = cx_reg + 12'd1;
            end
        end

        ov_next   = ov_reg && !out_ready;
        oa_next   = oa_reg;
        oc_next   = oc_reg;
        ok_next   = ok_reg;
        oe_next   = oe_reg;
        oerr_next = oerr_reg;
        ol_next   = ol_reg;
        if (emit || end_frame)
        begin
            ov_next   = 1'b1;
            oa_next   = emit ? row_reg + {12'd0, cx_reg} : 24'd0;
            oc_next   = emit ? colour : 24'd0;
            ok_next   = !emit ? KIND_STATUS : ((mode_reg == 2'd2) ? KIND_SUB : KIND_WRITE);
            oe_next   = end_frame;
            oerr_next = ERR_NONE;
            ol_next   = item_last;
            if (end_frame)
            begin
                if (pos_next == POS_BAD)
                begin
                    oerr_next = ERR_HDR;
                end
                else if (pos_next != POS_DONE)
                begin
                    oerr_next = ERR_SHORT;
                end
                pos_next  = 5'd0;
                pb_next   = 2'd0;
                op_next   = 8'd0;
                part_next = 16'd0;
                run_next  = 7'd0;
                acc_next  = 32'd0;
            end
        end

        stat.cls      = cls;
        stat.run_last = run_last;
        stat.out_free = !ov_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= 5'd0;
            mode_reg <= 2'd0;
            fw_reg   <= 13'd0;
            fh_reg   <= 13'd0;
            for (int i = 0; i < 4; i++)
            begin
                rb_reg[i] <= 12'd0;
            end
            cx_reg   <= 12'd0;
            cy_reg   <= 12'd0;
            prev_reg <= 24'd0;
            run_reg  <= 7'd0;
            vld_reg  <= '0;
            op_reg   <= 8'd0;
            pb_reg   <= 2'd0;
            part_reg <= 16'd0;
            acc_reg  <= 32'd0;
            row_reg  <= 24'd0;
            hold_reg <= 1'b0;
            ivld_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            mode_reg <= mode_next;
            fw_reg   <= fw_next;
            fh_reg   <= fh_next;
            for (int i = 0; i < 4; i++)
            begin
                rb_reg[i] <= rb_next[i];
            end
            cx_reg   <= cx_next;
            cy_reg   <= cy_next;
            prev_reg <= prev_next;
            run_reg  <= run_next;
            vld_reg  <= vld_next;
            op_reg   <= op_next;
            pb_reg   <= pb_next;
            part_reg <= part_next;
            acc_reg  <= acc_next;
            row_reg  <= row_next;
            hold_reg <= hold_next;
            ivld_reg <= ivld_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        oa_reg   <= oa_next;
        oc_reg   <= oc_next;
        ok_reg   <= ok_next;
        oe_reg   <= oe_next;
        oerr_reg <= oerr_next;
        ol_reg   <= ol_next;
    end

    assign out_valid     = ov_reg;
    assign pixel_address = oa_reg;
    assign red           = oc_reg[23:16];
    assign green         = oc_reg[15:8];
    assign blue          = oc_reg[7:0];
    assign kind          = ok_reg;
    assign frame_end     = oe_reg;
    assign error_code    = oerr_reg;
    assign last_of_item  = ol_reg;

endmodule
`default_nettype wire

// ===== design/qoi_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// QOI frame decoder controller
// Sequences byte intake, address setup, index lookups and run output.
// ----------------------------------------------------------------------------
module qoi_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire qoi_pkg::stat_t stat,
    output qoi_pkg::cmd_t       cmd
);
    import qoi_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SETUP = 2'd1;
    localparam logic [1:0] S_IDX   = 2'd2;
    localparam logic [1:0] S_RUN   = 2'd3;

    logic [1:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready   = stat.out_free;
                cmd.accept = in_valid && stat.out_free;
                if (cmd.accept)
                begin
                    case (stat.cls)
                        CLS_SETUP: state_next = S_SETUP;
                        CLS_INDEX: state_next = S_IDX;
                        CLS_RUN:   state_next = S_RUN;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = S_IDLE;
            end
            S_IDX:
            begin
                if (stat.out_free)
                begin
                    cmd.idx_emit = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                if (stat.out_free)
                begin
                    cmd.run_emit = 1'b1;
                    if (stat.run_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !in_ready)
        else $error("input ready while busy");

    a_setup_one: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SETUP |=> state_reg == S_IDLE)
        else $error("setup longer than one cycle");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.idx_emit || cmd.run_emit) |-> stat.out_free)
        else $error("emit into a full output register");

    a_index_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && stat.cls == CLS_INDEX) |=> state_reg == S_IDX)
        else $error("index lookup not started");

endmodule
`default_nettype wire
